### rtl/core/stereo_dynamic_range_compressor_core_defines.svh
// Assertion macros used by the checker file.
`ifndef STEREO_DYNAMIC_RANGE_COMPRESSOR_CORE_DEFINES_SVH
`define STEREO_DYNAMIC_RANGE_COMPRESSOR_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define SDRC_AST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define SDRC_AST_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/core/sdrc_pkg.sv
package sdrc_pkg;

    // shared multiplier: signed operands and full product
    localparam int MW = 34;
    typedef logic signed [MW-1:0]   t_mop;
    typedef logic signed [2*MW-1:0] t_mprod;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_GAIN = 3'd6;

    // power is unsigned Q1.47
    localparam int               POWER_FRAC  = 47;
    localparam logic [47:0]      POWER_ONE   = 48'h8000_0000_0000;
    localparam logic [47:0]      POWER_FLOOR = 48'd14;
    localparam logic [24:0]      COEF_ONE    = 25'h100_0000;
    localparam logic signed [MW-1:0] DB_PER_LOG2   = 34'sd197283; // 10*log10(2), Q16
    localparam logic signed [MW-1:0] LOG2_PER_DB20 = 34'sd10885;  // log2(10)/20, Q16
    localparam logic signed [31:0]   LEVEL_OFFSET  = 32'sd196608; // +3 dB, Q16

    // 2^(i/16) in Q16, 17 points
    function automatic logic [17:0] exp_tab(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110219;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/stereo_dynamic_range_compressor_core.sv
// Channel   Dir  Beat fields (low bit first)
// s_axis    in   tdata: left_in, right_in
// m_axis    out  tdata: left_out, right_out
// cfg       in   i_cfg_index selects register, i_cfg_data holds value
//
// Enabled: one shared signed 34x34 multiplier is stepped through power,
// mix, 6 normalise steps, 16 log squarings, gain and scaling, one beat
// at a time. Disabled: the beat is passed through unchanged.
// Synchronous active-low reset; no clearing pass.
// A finished result waits in the output register; the next beat is taken
// meanwhile, and a second result stalls only until the first is taken.
module stereo_dynamic_range_compressor_core #(
    parameter int BLOCK_SIZE   = 32,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sdrc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sdrc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int TDW   = ((2*SW+7)/8)*8;
    localparam int PBITS = 2*(SW-1);
    localparam int SHL   = (PBITS <= sdrc_pkg::POWER_FRAC) ? sdrc_pkg::POWER_FRAC-PBITS : 0;
    localparam int SHR   = (PBITS >  sdrc_pkg::POWER_FRAC) ? PBITS-sdrc_pkg::POWER_FRAC : 0;
    localparam int PRW   = SW + 18;           // |sample| * mantissa
    localparam int SHMAX = PRW + 1;           // any larger right shift gives zero
    localparam int POSW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int XW    = sdrc_pkg::MW - SW;

    // sequencer codes
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_SQ     = 5'd1;
    localparam logic [4:0] ST_MIX0   = 5'd2;
    localparam logic [4:0] ST_MIX1   = 5'd3;
    localparam logic [4:0] ST_MIX2   = 5'd4;
    localparam logic [4:0] ST_MIX3   = 5'd5;
    localparam logic [4:0] ST_NORM   = 5'd6;
    localparam logic [4:0] ST_LOG    = 5'd7;
    localparam logic [4:0] ST_LEVEL  = 5'd8;
    localparam logic [4:0] ST_EXC    = 5'd9;
    localparam logic [4:0] ST_GAIN0  = 5'd10;
    localparam logic [4:0] ST_GAIN1  = 5'd11;
    localparam logic [4:0] ST_XS     = 5'd12;
    localparam logic [4:0] ST_INTERP = 5'd13;
    localparam logic [4:0] ST_SCL_L  = 5'd14;
    localparam logic [4:0] ST_SCL_R  = 5'd15;
    localparam logic [4:0] ST_FIN    = 5'd16;

    // config registers
    logic                r_enable;
    logic signed [15:0]  r_thr;
    logic [19:0]         r_inv;
    logic [23:0]         r_lcoef;
    logic [23:0]         r_acoef;
    logic [23:0]         r_rcoef;
    logic signed [15:0]  r_post;

    // control and filter state
    logic [4:0]          r_state;
    logic [3:0]          r_cnt;
    logic [POSW-1:0]     r_pos;
    logic                r_end;
    logic                r_ovalid;
    logic [47:0]         r_power;
    logic signed [31:0]  r_gain;

    // working registers
    logic signed [SW-1:0] r_l, r_r;
    logic [SW-1:0]        r_m;
    logic [47:0]          r_pw;
    logic [73:0]          r_acc;
    logic [47:0]          r_norm;
    logic [5:0]           r_lz;
    logic [30:0]          r_sq;
    logic [15:0]          r_frac;
    logic signed [31:0]   r_level;
    logic signed [31:0]   r_tgt;
    logic signed [57:0]   r_gacc;
    logic signed [31:0]   r_x;
    logic [17:0]          r_mant;
    logic [SW-1:0]        r_lo, r_ro;
    logic [TDW-1:0]       r_odata;

    logic in_fire, out_fire, fin_go;
    logic signed [SW-1:0] in_l, in_r;
    logic [SW-1:0]        mag_l, mag_r;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = r_ovalid && m_axis_tready;
    assign fin_go   = (r_state == ST_FIN) && (!r_ovalid || m_axis_tready);
    assign in_l     = s_axis_tdata[SW-1:0];
    assign in_r     = s_axis_tdata[2*SW-1:SW];
    assign mag_l    = in_l[SW-1] ? SW'(-in_l) : SW'(in_l);
    assign mag_r    = in_r[SW-1] ? SW'(-in_r) : SW'(in_r);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign o_cfg_ready   = 1'b1;

    // gain smoothing constant: attack when the target falls below the held gain
    logic [24:0] g_coef, g_dcoef;
    assign g_coef  = (r_tgt < r_gain) ? {1'b0, r_acoef} : {1'b0, r_rcoef};
    assign g_dcoef = sdrc_pkg::COEF_ONE - g_coef;

    logic [24:0] l_dcoef;
    assign l_dcoef = sdrc_pkg::COEF_ONE - {1'b0, r_lcoef};

    // log2 of power, integer part as leading-zero count from bit 47
    logic signed [23:0] log_q16;
    assign log_q16 = $signed({8'b0, r_frac}) - $signed({2'b0, r_lz, 16'b0});

    logic signed [33:0] exc, tot;
    assign exc = {{2{r_level[31]}}, r_level} - {{10{r_thr[15]}}, r_thr, 8'b0};
    assign tot = {{2{r_gain[31]}}, r_gain} + {{10{r_post[15]}}, r_post, 8'b0};

    logic [17:0] tab_lo, tab_hi;
    assign tab_lo = sdrc_pkg::exp_tab({1'b0, r_x[15:12]});
    assign tab_hi = sdrc_pkg::exp_tab({1'b0, r_x[15:12]} + 5'd1);

    // shared multiplier, operands picked by the sequencer
    sdrc_pkg::t_mop   mul_a, mul_b;
    sdrc_pkg::t_mprod mul_p;

    always_comb begin
        unique case (r_state)
            ST_SQ: begin
                mul_a = {{XW{1'b0}}, r_m};
                mul_b = {{XW{1'b0}}, r_m};
            end
            ST_MIX0: begin
                mul_a = {10'b0, r_lcoef};
                mul_b = {10'b0, r_power[47:24]};
            end
            ST_MIX1: begin
                mul_a = {10'b0, r_lcoef};
                mul_b = {10'b0, r_power[23:0]};
            end
            ST_MIX2: begin
                mul_a = {9'b0, l_dcoef};
                mul_b = {10'b0, r_pw[47:24]};
            end
            ST_MIX3: begin
                mul_a = {9'b0, l_dcoef};
                mul_b = {10'b0, r_pw[23:0]};
            end
            ST_LOG: begin
                mul_a = {3'b0, r_sq};
                mul_b = {3'b0, r_sq};
            end
            ST_LEVEL: begin
                mul_a = {{10{log_q16[23]}}, log_q16};
                mul_b = sdrc_pkg::DB_PER_LOG2;
            end
            ST_EXC: begin
                mul_a = exc;
                mul_b = $signed({14'b0, r_inv}) - 34'sd65536;
            end
            ST_GAIN0: begin
                mul_a = {9'b0, g_coef};
                mul_b = {{2{r_gain[31]}}, r_gain};
            end
            ST_GAIN1: begin
                mul_a = {9'b0, g_dcoef};
                mul_b = {{2{r_tgt[31]}}, r_tgt};
            end
            ST_XS: begin
                mul_a = tot;
                mul_b = sdrc_pkg::LOG2_PER_DB20;
            end
            ST_INTERP: begin
                mul_a = {16'b0, tab_hi - tab_lo};
                mul_b = {22'b0, r_x[11:0]};
            end
            ST_SCL_L: begin
                mul_a = {{XW{1'b0}}, r_l[SW-1] ? SW'(-r_l) : SW'(r_l)};
                mul_b = {16'b0, r_mant};
            end
            ST_SCL_R: begin
                mul_a = {{XW{1'b0}}, r_r[SW-1] ? SW'(-r_r) : SW'(r_r)};
                mul_b = {16'b0, r_mant};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // squared peak brought to Q1.47
    logic [63:0] sq_pw;
    assign sq_pw = (mul_p[63:0] << SHL) >> SHR;

    // last mix step: round half up and drop 24 fraction bits
    logic [73:0] mix_sum;
    logic [47:0] mix_new;
    assign mix_sum = r_acc + {24'b0, mul_p[49:0]} + 74'h80_0000;
    assign mix_new = mix_sum[71:24];

    // normalise: binary search on leading zeros, 32/16/8/4/2/1
    logic [5:0]  nrm_s;
    logic        nrm_z;
    logic [47:0] nrm_nx;
    assign nrm_s  = 6'd32 >> r_cnt[2:0];
    assign nrm_z  = (r_norm >> (6'd48 - nrm_s)) == 48'd0;
    assign nrm_nx = nrm_z ? (r_norm << nrm_s) : r_norm;

    // one squaring round of the mantissa
    logic [31:0] log_t;
    assign log_t = mul_p[61:30];

    sdrc_pkg::t_mprod lvl_sum, tgt_sum, xs_sum, ip_sum;
    logic signed [57:0] g_sum;
    assign lvl_sum = mul_p + 68'sd32768;
    assign tgt_sum = mul_p + 68'sd32768;
    assign xs_sum  = mul_p + 68'sd32768;
    assign ip_sum  = mul_p + 68'sd2048;
    assign g_sum   = r_gacc + mul_p[57:0] + 58'sd8388608;

    // sample scaling by 2^ip * mant/2^16, on the magnitude, with saturation
    logic signed [17:0] sc_sh, sc_nsh;
    logic [5:0]         sc_shc;
    logic [63:0]        sc_prod, sc_r, sc_half;
    logic               sc_neg;
    logic [SW-1:0]      sc_out;

    always_comb begin
        sc_sh   = 18'sd16 - $signed({{2{r_x[31]}}, r_x[31:16]});
        sc_nsh  = -sc_sh;
        sc_prod = {{(64-PRW){1'b0}}, mul_p[PRW-1:0]};
        sc_half = 64'd1 << (SW-1);
        sc_neg  = (r_state == ST_SCL_L) ? r_l[SW-1] : r_r[SW-1];
        sc_shc  = (sc_sh > 18'(SHMAX)) ? 6'(SHMAX) : sc_sh[5:0];
        if (sc_sh >= 18'sd1) begin
            sc_r = (sc_prod + (64'd1 << (sc_shc - 6'd1))) >> sc_shc;
        end else if (sc_prod == 64'd0) begin
            sc_r = 64'd0;
        end else if (sc_sh <= -18'sd14) begin
            sc_r = sc_half;
        end else begin
            sc_r = sc_prod << sc_nsh[3:0];
        end
        if (sc_neg) begin
            if (sc_r > sc_half) sc_r = sc_half;
            sc_out = SW'(~sc_r[SW-1:0] + 1'b1);
        end else begin
            if (sc_r > sc_half - 64'd1) sc_r = sc_half - 64'd1;
            sc_out = sc_r[SW-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_thr    <= '0;
            r_inv    <= 20'd65536;
            r_lcoef  <= '0;
            r_acoef  <= '0;
            r_rcoef  <= '0;
            r_post   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sdrc_pkg::CFG_ENABLE:    r_enable <= i_cfg_data[0];
                sdrc_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data[15:0];
                sdrc_pkg::CFG_INV_RATIO: r_inv    <= i_cfg_data[19:0];
                sdrc_pkg::CFG_LEVEL:     r_lcoef  <= i_cfg_data;
                sdrc_pkg::CFG_ATTACK:    r_acoef  <= i_cfg_data;
                sdrc_pkg::CFG_RELEASE:   r_rcoef  <= i_cfg_data;
                sdrc_pkg::CFG_POST_GAIN: r_post   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_power  <= sdrc_pkg::POWER_ONE;
            r_gain   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_l   <= in_l;
                        r_r   <= in_r;
                        r_m   <= (mag_l > mag_r) ? mag_l : mag_r;
                        r_end <= (r_pos == POSW'(BLOCK_SIZE-1));
                        r_pos <= (r_pos == POSW'(BLOCK_SIZE-1)) ? '0 : r_pos + 1'b1;
                        if (r_enable) begin
                            r_state <= ST_SQ;
                        end else begin
                            r_lo    <= in_l;
                            r_ro    <= in_r;
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_SQ: begin
                    r_pw    <= sq_pw[47:0];
                    r_state <= ST_MIX0;
                end
                ST_MIX0: begin
                    r_acc   <= {mul_p[49:0], 24'b0};
                    r_state <= ST_MIX1;
                end
                ST_MIX1: begin
                    r_acc   <= r_acc + {24'b0, mul_p[49:0]};
                    r_state <= ST_MIX2;
                end
                ST_MIX2: begin
                    r_acc   <= r_acc + {mul_p[49:0], 24'b0};
                    r_state <= ST_MIX3;
                end
                ST_MIX3: begin
                    r_power <= mix_new;
                    r_norm  <= (mix_new == 48'd0) ? 48'd1 : mix_new; // zero power reads as 1 LSB
                    r_lz    <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    r_norm <= nrm_nx;
                    r_lz   <= r_lz + (nrm_z ? nrm_s : 6'd0);
                    if (r_cnt == 4'd5) begin
                        r_sq    <= nrm_nx[47:17];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_LOG;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end
                ST_LOG: begin
                    r_frac <= {r_frac[14:0], log_t[31]};
                    r_sq   <= log_t[31] ? log_t[31:1] : log_t[30:0];
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) r_state <= ST_LEVEL;
                end
                ST_LEVEL: begin
                    r_level <= lvl_sum[47:16] + sdrc_pkg::LEVEL_OFFSET;
                    // floor is applied after the log, at a block end only
                    if (r_end && (r_power < sdrc_pkg::POWER_FLOOR))
                        r_power <= sdrc_pkg::POWER_FLOOR;
                    r_state <= ST_EXC;
                end
                ST_EXC: begin
                    r_tgt   <= tgt_sum[67] ? tgt_sum[47:16] : 32'sd0; // attenuate only
                    r_state <= ST_GAIN0;
                end
                ST_GAIN0: begin
                    r_gacc  <= mul_p[57:0];
                    r_state <= ST_GAIN1;
                end
                ST_GAIN1: begin
                    r_gain  <= g_sum[55:24];
                    r_state <= ST_XS;
                end
                ST_XS: begin
                    r_x     <= xs_sum[47:16];
                    r_state <= ST_INTERP;
                end
                ST_INTERP: begin
                    r_mant  <= tab_lo + ip_sum[29:12];
                    r_state <= ST_SCL_L;
                end
                ST_SCL_L: begin
                    r_lo    <= sc_out;
                    r_state <= ST_SCL_R;
                end
                ST_SCL_R: begin
                    r_ro    <= sc_out;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_go) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result valid: set as a result is loaded, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin_go) begin
            r_ovalid <= 1'b1;
        end else if (out_fire) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register, payload only
    always_ff @(posedge i_clk) begin
        if (fin_go) r_odata <= TDW'({r_ro, r_lo});
    end

endmodule

### rtl/core/sdrc_checker.sv
`include "stereo_dynamic_range_compressor_core_defines.svh"

module sdrc_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    // stalled result beat holds
    `SDRC_AST(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped or changed under stall")

    // one beat at a time: busy right after taking a beat
    `SDRC_AST(a_in_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

    // reset leaves the block idle with no result pending
    `SDRC_AST_RST(a_rst_idle, !i_rst_n |=> s_axis_tready && !m_axis_tvalid, "not idle after reset")

endmodule

bind stereo_dynamic_range_compressor_core sdrc_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sdrc_checker (.*);
